/* rtl/acal_pkg.sv */
// Shared types and constants for the accelerometer offset calibrator.
// No dependencies; imported by the top level.
package acal_pkg;

   // fixed field widths
   localparam int OUT_W  = 48;   // result axis width, Q.FRAC_BITS
   localparam int CFG_W  = 16;   // widest configuration register
   localparam int OFF_W  = 32;   // stored axis offset
   localparam int OP_W   = 2;
   localparam int CSR_AW = 2;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_SENSITIVITY = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_CONV_COEF   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_GRAVITY     = 2'd2;

   // axis step codes; the gravity step follows the three axes when offsets are built
   localparam logic [1:0] AX_X    = 2'd0;
   localparam logic [1:0] AX_Y    = 2'd1;
   localparam logic [1:0] AX_Z    = 2'd2;
   localparam logic [1:0] AX_GRAV = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OFF_MUL,
      ST_OFF_ACC,
      ST_DONE
   } state_type;

endpackage

/* rtl/accel_offset_calibrator.sv */
// Top level of the accelerometer offset calibrator: ports, settings, sequencer.
// Depends on acal_pkg, acal_mul and acal_sdiv.
//
//   channel  direction  handshake                 payload
//   req_     in         req_tvalid / req_tready   tdata: raw_x, raw_y, raw_z; tuser: opcode
//   rsp_     out        rsp_tvalid / rsp_tready   tdata: out_x, out_y, out_z; tuser: status
//   csr_     in         csr_we (no wait)          csr_addr, csr_wdata
//
// DW is the divider width (49 at default settings). The three axes pass one after another
// through one bit-serial divider, one quotient bit per cycle; a calibration sample also passes
// each axis through the multiplier first. Start, opcode three and a sample with the count
// saturated go straight to the result; stop forms four products through the shared multiplier.
// Reset is synchronous; it clears mode, count, means and offsets and returns the settings to their defaults.
// A finished result waits in the output register while the next request is taken;
// the sequencer only stalls when a second result is ready before the first leaves.
module accel_offset_calibrator
   import acal_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,  // raw_x, raw_y, raw_z
   input  logic [OP_W-1:0]                       req_tuser,  // opcode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [3*OUT_W-1:0]                    rsp_tdata,  // out_x, out_y, out_z
   output logic                                  rsp_tuser,  // status
   input  logic                                  csr_we,
   input  logic [CSR_AW-1:0]                     csr_addr,
   input  logic [CFG_W-1:0]                      csr_wdata
);

   localparam int MA    = (SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W;
   localparam int MB    = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;
   localparam int PW    = MA + MB;
   localparam int TW    = PW - 8;
   localparam int SUM_W = PW + 1;
   localparam int CD_W  = OFF_W + 1 + FRAC_BITS;
   localparam int DW    = (SUM_W > CD_W) ? SUM_W : CD_W;
   localparam int VW    = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   // sequencer
   state_type state_ff, state_in;

   // settings
   logic        [CFG_W-1:0] sens_ff;
   logic signed [CFG_W-1:0] coef_ff;
   logic        [CFG_W-1:0] grav_ff;

   // calibration state
   logic                           cal_ff;
   logic [COUNT_WIDTH-1:0]         count_ff;
   logic signed [SAMPLE_WIDTH-1:0] mean_ff [3];
   logic signed [OFF_W-1:0]        off_ff  [3];

   // per-request working registers
   logic signed [SAMPLE_WIDTH-1:0] raw_ff [3];
   logic [1:0]                     ax_ff;
   logic                           upd_ff;
   logic                           neg_ff;
   logic [OUT_W-1:0]               res_ff [3];

   // output register
   logic               rsp_valid_ff;
   logic [3*OUT_W-1:0] rsp_data_ff;
   logic               rsp_stat_ff;

   // datapath nets
   opcode_type                     req_op;
   logic signed [SAMPLE_WIDTH-1:0] raw_in [3];
   logic signed [SAMPLE_WIDTH-1:0] raw_sel;
   logic signed [SAMPLE_WIDTH-1:0] mean_sel;
   logic signed [OFF_W-1:0]        off_sel;
   logic signed [MA-1:0]           mul_a;
   logic signed [MB-1:0]           mul_b;
   logic signed [PW-1:0]           prod;
   logic signed [PW-1:0]           prod_adj;
   logic signed [TW-1:0]           prod_q8;
   logic signed [SUM_W-1:0]        mean_sum;
   logic signed [OFF_W:0]          diff;
   logic signed [CD_W-1:0]         diff_q;
   logic signed [DW-1:0]           dvd;
   logic [DW-1:0]                  dvd_mag;
   logic [COUNT_WIDTH-1:0]         count_inc;
   logic [VW-1:0]                  dvs;
   logic                           div_start;
   logic                           div_done;
   logic [DW-1:0]                  quo;
   logic signed [DW:0]             quo_s;
   logic                           rsp_free;

   assign req_op   = opcode_type'(req_tuser);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // unpack request samples
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         raw_in[i] = req_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      end
   end

   // current axis selection
   always_comb begin
      case (ax_ff)
         AX_X: begin
            raw_sel  = raw_ff[0];
            mean_sel = mean_ff[0];
            off_sel  = off_ff[0];
         end
         AX_Y: begin
            raw_sel  = raw_ff[1];
            mean_sel = mean_ff[1];
            off_sel  = off_ff[1];
         end
         default: begin
            raw_sel  = raw_ff[2];
            mean_sel = mean_ff[2];
            off_sel  = off_ff[2];
         end
      endcase
   end

   // multiplier operands: mean * count, mean * coef, or coef * gravity
   always_comb begin
      if (state_ff == ST_OFF_MUL && ax_ff == AX_GRAV) begin
         mul_a = MA'(coef_ff);
         mul_b = MB'(signed'({1'b0, grav_ff}));
      end else if (state_ff == ST_OFF_MUL) begin
         mul_a = MA'(mean_sel);
         mul_b = MB'(coef_ff);
      end else begin
         mul_a = MA'(mean_sel);
         mul_b = MB'(signed'({1'b0, count_ff}));
      end
   end

   acal_mul #(
      .AW(MA),
      .BW(MB)
   ) u_mul (
      .clock(clock),
      .a    (mul_a),
      .b    (mul_b),
      .p    (prod)
   );

   // product / 256 rounded toward zero
   always_comb begin
      prod_adj = prod + (prod[PW-1] ? PW'(255) : PW'(0));
      prod_q8  = TW'(prod_adj >>> 8);
   end

   // divider operands: running mean update or calibrated output
   always_comb begin
      mean_sum  = SUM_W'(prod) + SUM_W'(raw_sel);
      diff      = (OFF_W+1)'(raw_sel) - (OFF_W+1)'(off_sel);
      diff_q    = CD_W'(diff) <<< FRAC_BITS;
      dvd       = upd_ff ? DW'(mean_sum) : DW'(diff_q);
      dvd_mag   = dvd[DW-1] ? DW'(-dvd) : DW'(dvd);
      count_inc = count_ff + COUNT_WIDTH'(1);
      if (upd_ff) begin
         dvs = VW'(count_inc);
      end else if (sens_ff == '0) begin
         dvs = VW'(1);
      end else begin
         dvs = VW'(sens_ff);
      end
      quo_s = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   end

   acal_sdiv #(
      .DW(DW),
      .VW(VW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(dvd_mag),
      .divisor (dvs),
      .done    (div_done),
      .quotient(quo)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_op)
                  OP_STOP: begin
                     state_in = ST_OFF_MUL;
                  end
                  OP_SAMPLE: begin
                     if (!cal_ff) begin
                        state_in = ST_DIV_GO;
                     end else if (count_ff != '1) begin
                        state_in = ST_MUL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (ax_ff == AX_Z) begin
                  state_in = ST_DONE;
               end else if (upd_ff) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_OFF_MUL: begin
            state_in = ST_OFF_ACC;
         end
         ST_OFF_ACC: begin
            state_in = (ax_ff == AX_GRAV) ? ST_DONE : ST_OFF_MUL;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // settings, calibration state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff      <= CFG_W'(1);
         coef_ff      <= CFG_W'(256);
         grav_ff      <= '0;
         cal_ff       <= 1'b0;
         count_ff     <= '0;
         mean_ff      <= '{default: '0};
         off_ff       <= '{default: '0};
         ax_ff        <= AX_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SENSITIVITY: sens_ff <= csr_wdata;
               CSR_CONV_COEF:   coef_ff <= csr_wdata;
               CSR_GRAVITY:     grav_ff <= csr_wdata;
               default: ;
            endcase
         end

         // output valid: set when a result is loaded, cleared when taken
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               ax_ff <= AX_X;
               if (req_tvalid) begin
                  if (req_op == OP_START) begin
                     count_ff <= '0;
                     off_ff   <= '{default: '0};
                     cal_ff   <= 1'b1;
                  end else if (req_op == OP_STOP) begin
                     cal_ff <= 1'b0;
                  end
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (upd_ff) begin
                     for (int i = 0; i < 3; i++) begin
                        if (ax_ff == 2'(i)) begin
                           mean_ff[i] <= SAMPLE_WIDTH'(quo_s);
                        end
                     end
                     if (ax_ff == AX_Z) begin
                        count_ff <= count_inc;
                     end
                  end
                  ax_ff <= ax_ff + 2'd1;
               end
            end
            ST_OFF_ACC: begin
               // scaled means, then the gravity term comes off z
               for (int i = 0; i < 3; i++) begin
                  if (ax_ff == 2'(i)) begin
                     off_ff[i] <= OFF_W'(prod_q8);
                  end
               end
               if (ax_ff == AX_GRAV) begin
                  off_ff[2] <= off_ff[2] - OFF_W'(prod_q8);
               end
               ax_ff <= ax_ff + 2'd1;
            end
            default: ;
         endcase
      end
   end

   // request payload, per-axis results and output payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               upd_ff <= (req_op == OP_SAMPLE) && cal_ff && (count_ff != '1);
               for (int i = 0; i < 3; i++) begin
                  raw_ff[i] <= raw_in[i];
                  res_ff[i] <= (req_op == OP_SAMPLE && cal_ff) ?
                               OUT_W'(raw_in[i]) << FRAC_BITS : '0;
               end
            end
         end
         ST_DIV_GO: begin
            neg_ff <= dvd[DW-1];
         end
         ST_DIV_WAIT: begin
            if (div_done && !upd_ff) begin
               for (int i = 0; i < 3; i++) begin
                  if (ax_ff == 2'(i)) begin
                     res_ff[i] <= OUT_W'(quo_s);
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
               rsp_stat_ff <= !cal_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

endmodule

/* rtl/acal_mul.sv */
// Registered signed multiplier used for mean scaling and offset products.
// Standalone; no package needed.
module acal_mul #(
   parameter int AW = 16,
   parameter int BW = 17
) (
   input  logic                 clock,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);

   logic signed [AW+BW-1:0] p_ff;

   // one product per cycle, registered
   always_ff @(posedge clock) begin
      p_ff <= (AW+BW)'(a) * (AW+BW)'(b);
   end

   assign p = p_ff;

endmodule

/* rtl/acal_sdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Standalone; no package needed.
module acal_sdiv #(
   parameter int DW = 49,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [VW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [VW-1:0] dvs_ff;

   logic [VW:0]   trial;
   logic [VW:0]   trial_sub;
   logic          fits;

   // partial remainder shifted left by one dividend bit
   always_comb begin
      trial     = {rem_ff, quo_ff[DW-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = (trial >= {1'b0, dvs_ff});
   end

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CW'(DW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? trial_sub[VW-1:0] : trial[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
